// File: hw/rtl/wpvd_pkg.sv
// wpvd_pkg: shared types and constants of the windowed peak and valley detector
// used by wpvd_store and windowed_peak_valley_detector, depends on nothing
`default_nettype none

package wpvd_pkg;

  // width of index and window arithmetic (index plus half window, up to 126)
  localparam int unsigned POS_W = 7;

  // smallest trace that is searched
  localparam int unsigned MIN_TRACE = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMINENCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST   = 8'd1;

  localparam int unsigned PROM_W = 16;
  localparam int unsigned DIST_W = 6;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned X_W = 32;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PEAK   = 2'd1,
    KIND_VALLEY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_LIM  = 7'b0000010,
    S_CTR  = 7'b0000100,
    S_CLD  = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_DEC  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  // control of the sample store
  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [POS_W-1:0] rd_addr;
  } store_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/windowed_peak_valley_detector.sv
// windowed_peak_valley_detector: loads a trace of (x, y) samples, then emits kept peaks and valleys
// depends on wpvd_pkg and wpvd_store
// loading: one sample transfer per cycle while no search runs
// search: starts in the cycle after the tlast transfer; each index runs S_CTR, S_CLD, S_SCAN and S_DEC,
//   the scan reading the clipped 2W+1 window through the single store read port
// a result waits in a one-deep hold register until the next kept point or the end of the scan
// reset (rst_ni low, asynchronous): control cleared, prominence 0, min_distance 1, stores not cleared
`default_nettype none

module windowed_peak_valley_detector #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration write channel
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [wpvd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [wpvd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: x_value (32), y_sample (SAMPLE_BITS), zero fill
  input  wire  [((32+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire                               s_axis_tlast,   // last_sample
  // result output stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata from bit 0: sample_index (6), point_x (32), point_y (SAMPLE_BITS), zero fill
  output logic [((38+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser from bit 0: point_kind (2), status (2)
  output logic [3:0]                        m_axis_tuser,
  output logic                              m_axis_tlast    // last_of_run
);

  localparam int unsigned POS_W = wpvd_pkg::POS_W;
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned XW    = wpvd_pkg::X_W;
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned LIM_W = wpvd_pkg::PROM_W + SB + 1;
  localparam int unsigned OUT_W = ((38 + SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(wpvd_pkg::MIN_TRACE);

  // ---------------------------------------------------------------- registers
  wpvd_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             short_q, short_d;
  logic [POS_W-1:0] i_q, i_d;
  logic [POS_W-1:0] j_q, j_d;
  logic [POS_W-1:0] hi_q, hi_d;
  logic             pk_q, pk_d, vl_q, vl_d;
  logic             pk_seen_q, pk_seen_d, vl_seen_q, vl_seen_d;
  logic             held_vld_q, held_vld_d;
  logic             out_vld_q, out_vld_d;
  logic [wpvd_pkg::PROM_W-1:0] prom_q, prom_d;
  logic [wpvd_pkg::DIST_W-1:0] mind_q, mind_d;

  // payload, no reset
  logic signed [SB-1:0] min_q, min_d, max_q, max_d;
  logic [LIM_W-1:0]     lim_q, lim_d;
  logic signed [SB-1:0] cy_q, cy_d, wmin_q, wmin_d, wmax_q, wmax_d;
  logic [XW-1:0]        cx_q, cx_d;
  logic [POS_W-1:0]     pk_pos_q, pk_pos_d, vl_pos_q, vl_pos_d;
  wpvd_pkg::kind_e      held_kind_q, held_kind_d;
  logic [POS_W-1:0]     held_idx_q, held_idx_d;
  logic [XW-1:0]        held_x_q, held_x_d;
  logic [SB-1:0]        held_y_q, held_y_d;
  wpvd_pkg::kind_e      out_kind_q, out_kind_d;
  wpvd_pkg::status_e    out_st_q, out_st_d;
  logic [POS_W-1:0]     out_idx_q, out_idx_d;
  logic [XW-1:0]        out_x_q, out_x_d;
  logic [SB-1:0]        out_y_q, out_y_d;
  logic                 out_last_q, out_last_d;

  // ---------------------------------------------------------------- store
  wpvd_pkg::store_ctl_t store_ctl;
  logic [XW-1:0]        rd_x;
  logic [SB-1:0]        rd_y_raw;
  logic signed [SB-1:0] rd_y;
  logic [XW-1:0]        in_x;
  logic signed [SB-1:0] in_y;

  assign in_x = s_axis_tdata[XW-1:0];
  assign in_y = s_axis_tdata[XW +: SB];
  assign rd_y = rd_y_raw;

  wpvd_store #(
    .DEPTH (MAX_SAMPLES),
    .YW    (SB)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (store_ctl),
    .wr_x_i (in_x),
    .wr_y_i (in_y),
    .rd_x_o (rd_x),
    .rd_y_o (rd_y_raw)
  );

  // ---------------------------------------------------------------- datapath helpers
  logic                       s_xfer, cfg_xfer, out_free;
  logic [wpvd_pkg::DIST_W-1:0] w_eff;
  logic [POS_W-1:0]           w_pos, n_pos, i_plus_w, lo;
  logic [SB:0]                range_w, d_pk, d_vl;
  logic                       pk_go, vl_go, keep, stall;
  wpvd_pkg::status_e          st_cur;

  assign s_axis_tready = (state_q == wpvd_pkg::S_LOAD);
  assign cfg_ready_o   = 1'b1;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;
  assign out_free      = !out_vld_q || m_axis_tready;

  // min_distance 0 behaves as 1
  assign w_eff    = (mind_q == '0) ? wpvd_pkg::DIST_W'(1) : mind_q;
  assign w_pos    = POS_W'(w_eff);
  assign n_pos    = POS_W'(count_q);
  assign i_plus_w = i_q + w_pos;
  assign lo       = (i_q >= w_pos) ? (i_q - w_pos) : '0;

  // differences are never negative, so they fit SB+1 unsigned bits
  assign range_w = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
  assign d_pk    = {cy_q[SB-1], cy_q} - {wmin_q[SB-1], wmin_q};
  assign d_vl    = {wmax_q[SB-1], wmax_q} - {cy_q[SB-1], cy_q};

  // spacing test: no earlier kept point stands for one far enough back
  assign pk_go = pk_q && (!pk_seen_q || ((i_q - pk_pos_q) >= w_pos));
  assign vl_go = vl_q && (!vl_seen_q || ((i_q - vl_pos_q) >= w_pos));

  // the valley test runs only when the peak test did not apply
  always_comb begin
    if (pk_go) begin
      keep = ({d_pk, 16'b0} >= lim_q);
    end else if (vl_go) begin
      keep = ({d_vl, 16'b0} >= lim_q);
    end else begin
      keep = 1'b0;
    end
  end

  // a new kept point pushes the held one out, which needs a free output slot
  assign stall = keep && held_vld_q && !out_free;

  assign st_cur = short_q ? wpvd_pkg::ST_SHORT : (ovf_q ? wpvd_pkg::ST_DROP : wpvd_pkg::ST_OK);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    short_d     = short_q;
    i_d         = i_q;
    j_d         = j_q;
    hi_d        = hi_q;
    pk_d        = pk_q;
    vl_d        = vl_q;
    pk_seen_d   = pk_seen_q;
    vl_seen_d   = vl_seen_q;
    held_vld_d  = held_vld_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    prom_d      = prom_q;
    mind_d      = mind_q;
    min_d       = min_q;
    max_d       = max_q;
    lim_d       = lim_q;
    cy_d        = cy_q;
    cx_d        = cx_q;
    wmin_d      = wmin_q;
    wmax_d      = wmax_q;
    pk_pos_d    = pk_pos_q;
    vl_pos_d    = vl_pos_q;
    held_kind_d = held_kind_q;
    held_idx_d  = held_idx_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    out_kind_d  = out_kind_q;
    out_st_d    = out_st_q;
    out_idx_d   = out_idx_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;

    store_ctl.wr_en   = 1'b0;
    store_ctl.wr_addr = POS_W'(count_q);
    store_ctl.rd_addr = i_q;

    // register writes are for the user to make only while idle; the block itself does not enforce it
    if (cfg_xfer) begin
      case (cfg_index_i)
        wpvd_pkg::CFG_PROMINENCE: prom_d = cfg_data_i;
        wpvd_pkg::CFG_MIN_DIST:   mind_d = cfg_data_i[wpvd_pkg::DIST_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      wpvd_pkg::S_LOAD: begin
        if (s_xfer) begin
          if (count_q < CNT_MAX) begin
            store_ctl.wr_en = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (count_q == '0) begin
              min_d = in_y;
              max_d = in_y;
            end else begin
              if (in_y < min_q) min_d = in_y;
              if (in_y > max_q) max_d = in_y;
            end
          end else begin
            // past capacity: dropped, flagged
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            i_d        = '0;
            pk_seen_d  = 1'b0;
            vl_seen_d  = 1'b0;
            held_vld_d = 1'b0;
            if (count_d < CNT_MIN) begin
              short_d = 1'b1;
              state_d = wpvd_pkg::S_FIN;
            end else begin
              state_d = wpvd_pkg::S_LIM;
            end
          end
        end
      end

      wpvd_pkg::S_LIM: begin
        // absolute threshold in Q.16 units
        lim_d   = LIM_W'(prom_q) * LIM_W'(range_w);
        state_d = wpvd_pkg::S_CTR;
      end

      wpvd_pkg::S_CTR: begin
        // fetch the center sample, fix the upper window edge
        store_ctl.rd_addr = i_q;
        hi_d    = (i_plus_w > (n_pos - POS_W'(1))) ? (n_pos - POS_W'(1)) : i_plus_w;
        state_d = wpvd_pkg::S_CLD;
      end

      wpvd_pkg::S_CLD: begin
        cy_d   = rd_y;
        cx_d   = rd_x;
        wmin_d = rd_y;
        wmax_d = rd_y;
        pk_d   = 1'b1;
        vl_d   = 1'b1;
        store_ctl.rd_addr = lo;
        j_d     = lo + POS_W'(1);
        state_d = wpvd_pkg::S_SCAN;
      end

      wpvd_pkg::S_SCAN: begin
        // rd_y holds the neighbor at address j_q - 1
        if (rd_y > cy_q)   pk_d   = 1'b0;
        if (rd_y < cy_q)   vl_d   = 1'b0;
        if (rd_y < wmin_q) wmin_d = rd_y;
        if (rd_y > wmax_q) wmax_d = rd_y;
        if (j_q <= hi_q) begin
          store_ctl.rd_addr = j_q;
          j_d = j_q + POS_W'(1);
        end else begin
          state_d = wpvd_pkg::S_DEC;
        end
      end

      wpvd_pkg::S_DEC: begin
        if (!stall) begin
          if (keep) begin
            if (held_vld_q) begin
              out_vld_d  = 1'b1;
              out_kind_d = held_kind_q;
              out_idx_d  = held_idx_q;
              out_x_d    = held_x_q;
              out_y_d    = held_y_q;
              out_st_d   = st_cur;
              out_last_d = 1'b0;
            end
            held_vld_d = 1'b1;
            held_idx_d = i_q;
            held_x_d   = cx_q;
            held_y_d   = cy_q;
            if (pk_go) begin
              held_kind_d = wpvd_pkg::KIND_PEAK;
              pk_seen_d   = 1'b1;
              pk_pos_d    = i_q;
            end else begin
              held_kind_d = wpvd_pkg::KIND_VALLEY;
              vl_seen_d   = 1'b1;
              vl_pos_d    = i_q;
            end
          end
          if ((i_q + POS_W'(1)) < n_pos) begin
            i_d     = i_q + POS_W'(1);
            state_d = wpvd_pkg::S_CTR;
          end else begin
            state_d = wpvd_pkg::S_FIN;
          end
        end
      end

      wpvd_pkg::S_FIN: begin
        // closing transfer: the held point, or an empty result
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_st_d   = st_cur;
          out_last_d = 1'b1;
          if (held_vld_q) begin
            out_kind_d = held_kind_q;
            out_idx_d  = held_idx_q;
            out_x_d    = held_x_q;
            out_y_d    = held_y_q;
          end else begin
            out_kind_d = wpvd_pkg::KIND_NONE;
            out_idx_d  = '0;
            out_x_d    = '0;
            out_y_d    = '0;
          end
          held_vld_d = 1'b0;
          count_d    = '0;
          ovf_d      = 1'b0;
          short_d    = 1'b0;
          state_d    = wpvd_pkg::S_LOAD;
        end
      end

      default: begin
        state_d = wpvd_pkg::S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wpvd_pkg::S_LOAD;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      short_q    <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      hi_q       <= '0;
      pk_q       <= 1'b0;
      vl_q       <= 1'b0;
      pk_seen_q  <= 1'b0;
      vl_seen_q  <= 1'b0;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      prom_q     <= '0;
      mind_q     <= wpvd_pkg::DIST_W'(1);
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      short_q    <= short_d;
      i_q        <= i_d;
      j_q        <= j_d;
      hi_q       <= hi_d;
      pk_q       <= pk_d;
      vl_q       <= vl_d;
      pk_seen_q  <= pk_seen_d;
      vl_seen_q  <= vl_seen_d;
      held_vld_q <= held_vld_d;
      out_vld_q  <= out_vld_d;
      prom_q     <= prom_d;
      mind_q     <= mind_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    min_q       <= min_d;
    max_q       <= max_d;
    lim_q       <= lim_d;
    cy_q        <= cy_d;
    cx_q        <= cx_d;
    wmin_q      <= wmin_d;
    wmax_q      <= wmax_d;
    pk_pos_q    <= pk_pos_d;
    vl_pos_q    <= vl_pos_d;
    held_kind_q <= held_kind_d;
    held_idx_q  <= held_idx_d;
    held_x_q    <= held_x_d;
    held_y_q    <= held_y_d;
    out_kind_q  <= out_kind_d;
    out_st_q    <= out_st_d;
    out_idx_q   <= out_idx_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_last_q  <= out_last_d;
  end

  // ---------------------------------------------------------------- outputs
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_y_q, out_x_q, out_idx_q[wpvd_pkg::IDX_OUT_W-1:0]});
  assign m_axis_tuser  = {out_st_q, out_kind_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- assertions
  // the scan never reads past the window edge
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpvd_pkg::S_SCAN) |-> (j_q <= (hi_q + POS_W'(1))))
    else $error("window scan ran past its upper edge");

  // drops only happen with a full store
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CNT_MAX))
    else $error("overflow flagged with room left in the store");

  // a decided index lies inside the loaded trace
  a_dec_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpvd_pkg::S_DEC) |-> (n_pos > i_q))
    else $error("decision on an index beyond the trace");

  // the end of a run always leaves the hold register empty and returns to loading
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == wpvd_pkg::S_FIN) && out_free) |=>
      ((state_q == wpvd_pkg::S_LOAD) && !held_vld_q && out_vld_q && out_last_q))
    else $error("run did not close with a final transfer");

endmodule

`default_nettype wire

// File: hw/rtl/wpvd_store.sv
// wpvd_store: x and y sample memories, one write and one registered read port
// depends on wpvd_pkg
`default_nettype none

module wpvd_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned YW    = 16
) (
  input  wire                       clk_i,
  input  wpvd_pkg::store_ctl_t      ctl_i,
  input  wire  [wpvd_pkg::X_W-1:0]  wr_x_i,
  input  wire  [YW-1:0]             wr_y_i,
  output logic [wpvd_pkg::X_W-1:0]  rd_x_o,
  output logic [YW-1:0]             rd_y_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [wpvd_pkg::X_W-1:0] x_mem [DEPTH];
  logic [YW-1:0]            y_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      x_mem[ctl_i.wr_addr[AW-1:0]] <= wr_x_i;
      y_mem[ctl_i.wr_addr[AW-1:0]] <= wr_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_x_o <= x_mem[ctl_i.rd_addr[AW-1:0]];
    rd_y_o <= y_mem[ctl_i.rd_addr[AW-1:0]];
  end

endmodule

`default_nettype wire

// File: sim/wpvd_checker.sv
`timescale 1ns / 1ps
// wpvd_checker: watches the config, sample and result channels of the peak and valley detector,
// predicts every result from the accepted samples and compares results in order
// depends on wpvd_pkg
module wpvd_checker
  import wpvd_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  input  wire                   cfg_ready_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  input  wire                   s_tvalid_i,
  input  wire                   s_tready_i,
  input  wire  [47:0]           s_tdata_i,  // x_value (32), y_sample (16)
  input  wire                   s_tlast_i,
  input  wire                   m_tvalid_i,
  input  wire                   m_tready_i,
  input  wire  [55:0]           m_tdata_i,  // sample_index (6), point_x (32), point_y (16), fill
  input  wire  [3:0]            m_tuser_i,  // point_kind (2), status (2)
  input  wire                   m_tlast_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int TRACE_DEPTH = 64;
  localparam int SPAN_FACTOR = 2;

  typedef struct {
    kind_e       kind;
    logic [5:0]  index;
    logic [31:0] x;
    logic [15:0] y;
    status_e     status;
    logic        last;
  } point_t;

  point_t points_due [$];

  logic [15:0]        prom;
  logic [5:0]         min_dist;
  logic signed [15:0] trace_y [TRACE_DEPTH];
  logic [31:0]        trace_x [TRACE_DEPTH];
  int                 n_loaded;
  bit                 dropped;
  logic signed [15:0] lo_y;
  logic signed [15:0] hi_y;

  int errors = 0;
  int pending = 0;
  assign errors_o  = errors;
  assign pending_o = pending;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic load_sample(input logic [31:0] x, input logic signed [15:0] y);
    if (n_loaded < TRACE_DEPTH) begin
      if (n_loaded == 0) begin
        lo_y = y;
        hi_y = y;
      end else begin
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
      end
      trace_y[n_loaded] = y;
      trace_x[n_loaded] = x;
      n_loaded++;
    end else begin
      dropped = 1'b1;
    end
  endtask

  // search the loaded trace and queue the points it should yield
  task automatic detect_extrema();
    int                 w, lo, hi, last_pk, last_vl, kept;
    longint             lim, rise;
    logic signed [15:0] wmin, wmax;
    bit                 pk, vl;
    status_e            st;
    if (n_loaded < MIN_TRACE) begin
      points_due.push_back('{KIND_NONE, 6'd0, 32'd0, 16'd0, ST_SHORT, 1'b1});
    end else begin
      st = dropped ? ST_DROP : ST_OK;
      lim = longint'(prom) * (longint'(hi_y) - longint'(lo_y));
      w = (min_dist == 0) ? 1 : int'(min_dist);
      last_pk = -SPAN_FACTOR * w;
      last_vl = -SPAN_FACTOR * w;
      kept = 0;
      for (int i = 0; i < n_loaded; i++) begin
        lo = (i - w < 0) ? 0 : i - w;
        hi = (i + w > n_loaded - 1) ? n_loaded - 1 : i + w;
        pk = 1'b1;
        vl = 1'b1;
        wmin = trace_y[i];
        wmax = trace_y[i];
        for (int j = lo; j <= hi; j++) begin
          if (trace_y[j] > trace_y[i]) pk = 1'b0;
          if (trace_y[j] < trace_y[i]) vl = 1'b0;
          if (trace_y[j] < wmin) wmin = trace_y[j];
          if (trace_y[j] > wmax) wmax = trace_y[j];
        end
        // peak wins on a flat stretch, valley only when the peak test is skipped
        if (pk && i - last_pk >= w) begin
          rise = longint'(trace_y[i]) - longint'(wmin);
          if (rise * 65536 >= lim) begin
            points_due.push_back('{KIND_PEAK, 6'(i), trace_x[i], trace_y[i], st, 1'b0});
            last_pk = i;
            kept++;
          end
        end else if (vl && i - last_vl >= w) begin
          rise = longint'(wmax) - longint'(trace_y[i]);
          if (rise * 65536 >= lim) begin
            points_due.push_back('{KIND_VALLEY, 6'(i), trace_x[i], trace_y[i], st, 1'b0});
            last_vl = i;
            kept++;
          end
        end
      end
      if (kept == 0) points_due.push_back('{KIND_NONE, 6'd0, 32'd0, 16'd0, st, 1'b0});
      points_due[points_due.size() - 1].last = 1'b1;
    end
    n_loaded = 0;
    dropped  = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result();
    point_t want;
    if (points_due.size() == 0) begin
      report($sformatf("result with nothing pending, tdata %h tuser %h", m_tdata_i, m_tuser_i));
    end else begin
      want = points_due.pop_front();
      compare_field("point_kind", m_tuser_i[1:0], want.kind);
      compare_field("status", m_tuser_i[3:2], want.status);
      compare_field("sample_index", m_tdata_i[5:0], want.index);
      compare_field("point_x", m_tdata_i[37:6], want.x);
      compare_field("point_y", m_tdata_i[53:38], want.y);
      compare_field("last_of_run", m_tlast_i, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prom     = '0;
      min_dist = 6'd1;
      n_loaded = 0;
      dropped  = 1'b0;
      points_due.delete();
      pending  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PROMINENCE: prom = cfg_data_i[15:0];
          CFG_MIN_DIST:   min_dist = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        load_sample(s_tdata_i[31:0], s_tdata_i[47:32]);
        if (s_tlast_i) detect_extrema();
      end
      if (m_tvalid_i && m_tready_i) check_result();
      pending = points_due.size();
    end
  end

endmodule

// File: sim/tb_windowed_peak_valley_detector.sv
`timescale 1ns / 1ps
// tb_windowed_peak_valley_detector: sample traces, register writes and verdict for the detector
// depends on wpvd_pkg, windowed_peak_valley_detector and wpvd_checker
module tb_windowed_peak_valley_detector;
  import wpvd_pkg::*;

  localparam int SAMPLE_BITS  = 16;
  localparam int S_DATA_W     = ((32 + SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_DATA_W     = ((38 + SAMPLE_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 280;
  // quiet cycles after the last result before the next register writes
  localparam int DRAIN_CYCLES = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // sample stream
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;  // x_value (32), y_sample (16)
  logic                s_axis_tlast  = 1'b0;

  // result stream
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // sample_index (6), point_x (32), point_y (16), fill
  logic [3:0]          m_axis_tuser;        // point_kind (2), status (2)
  logic                m_axis_tlast;

  int errors;
  int pending;

  // percent of cycles in which each side holds back
  int send_idle = 26;
  int recv_idle = 87;
  int items_sent = 0;

  always #5 clk_i = ~clk_i;

  windowed_peak_valley_detector #(
    .MAX_SAMPLES(64),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  wpvd_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // one sample transfer, with random gaps ahead of it
  task automatic push_sample(input logic [31:0] x, input logic [15:0] y, input bit last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // one register write, channel released before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the sender until every pending result has come out and the search has wound down
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // a trace of random shape: full range noise, small values full of ties,
  // a random walk, or only the extremes and zero
  task automatic send_trace(input int len);
    int          shape;
    int          level;
    logic [15:0] y;
    shape = $urandom_range(3);
    level = int'($urandom_range(65535)) - 32768;
    for (int k = 0; k < len; k++) begin
      case (shape)
        0: y = 16'($urandom);
        1: y = 16'(int'($urandom_range(4)) - 2);
        2: begin
          level += int'($urandom_range(2000)) - 1000;
          if (level > 32767) level = 32767;
          if (level < -32768) level = -32768;
          y = 16'(level);
        end
        default: begin
          case ($urandom_range(2))
            0: y = 16'h8000;
            1: y = 16'h7FFF;
            default: y = '0;
          endcase
        end
      endcase
      push_sample($urandom, y, k == len - 1);
    end
  endtask

  // both registers, biased toward the extremes
  task automatic random_config();
    int          r;
    logic [15:0] prom;
    logic [5:0]  min_dist;
    r = $urandom_range(99);
    if (r < 30) prom = '0;
    else if (r < 40) prom = 16'hFFFF;
    else if (r < 55) prom = 16'($urandom);
    else prom = 16'($urandom_range(8192));
    r = $urandom_range(99);
    if (r < 10) min_dist = '0;
    else if (r < 30) min_dist = 6'd1;
    else if (r < 38) min_dist = 6'd63;
    else if (r < 48) min_dist = 6'($urandom_range(63));
    else min_dist = 6'($urandom_range(6, 2));
    write_reg(CFG_PROMINENCE, prom);
    write_reg(CFG_MIN_DIST, {10'd0, min_dist});
  endtask

  initial begin
    int r, len, base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed traces at reset-like settings
    write_reg(CFG_PROMINENCE, 16'd0);
    write_reg(CFG_MIN_DIST, 16'd1);
    // single sample, too short to search
    push_sample(32'hFFFF_FFFF, 16'h8000, 1'b1);
    // two samples, still too short
    push_sample(32'h0000_0000, 16'h7FFF, 1'b0);
    push_sample(32'h0000_0001, 16'h8000, 1'b1);
    // minimal trace with a full-scale peak in the middle
    push_sample(32'h8000_0000, 16'h8000, 1'b0);
    push_sample(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
    push_sample(32'h0000_0000, 16'h8000, 1'b1);
    // flat trace: every point ties, peak test goes first
    push_sample(32'h5555_5555, 16'h0007, 1'b0);
    push_sample(32'hAAAA_AAAA, 16'h0007, 1'b0);
    push_sample(32'h0F0F_0F0F, 16'h0007, 1'b0);
    push_sample(32'hF0F0_F0F0, 16'h0007, 1'b1);
    // full-scale valley between two maxima
    push_sample(32'h0000_0010, 16'h7FFF, 1'b0);
    push_sample(32'h0000_0020, 16'h8000, 1'b0);
    push_sample(32'h0000_0030, 16'h7FFF, 1'b0);
    push_sample(32'h0000_0040, 16'h0000, 1'b0);
    push_sample(32'h0000_0050, 16'h0005, 1'b1);
    drain();

    // strictest threshold, window of zero acting as one: nothing is kept
    write_reg(CFG_PROMINENCE, 16'hFFFF);
    write_reg(CFG_MIN_DIST, 16'd0);
    push_sample(32'h1234_5678, 16'd0, 1'b0);
    push_sample(32'h2345_6789, 16'd5, 1'b0);
    push_sample(32'h3456_789A, 16'd4, 1'b0);
    push_sample(32'h4567_89AB, 16'd5, 1'b0);
    push_sample(32'h5678_9ABC, 16'd10, 1'b1);

    // random traces in three idling phases, registers rewritten between groups
    base = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 26;
          recv_idle = 87;
        end
        1: begin
          send_idle = 87;
          recv_idle = 26;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      do begin
        drain();
        random_config();
        repeat ($urandom_range(4, 1)) begin
          r = $urandom_range(99);
          // mostly short traces, some too short, a few near or past capacity
          if (r < 8) len = $urandom_range(2, 1);
          else if (r < 90) len = $urandom_range(24, 3);
          else len = $urandom_range(70, 60);
          send_trace(len);
        end
      end while (items_sent < base + (phase + 1) * RANDOM_ITEMS / 3);
    end
    drain();

    if (errors == 0) begin
      $display("[windowed_peak_valley_detector] OK");
    end else begin
      $display("[windowed_peak_valley_detector] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("[windowed_peak_valley_detector] ERROR");
    $finish;
  end

endmodule
